### rtl/repeating_timer_table_defines.svh
// ----------------------------------------------------------------------------
// Repeating timer table assertion macros
// Shared assertion wrappers for the repeating timer table.
// ----------------------------------------------------------------------------
`ifndef REPEATING_TIMER_TABLE_DEFINES_SVH
`define REPEATING_TIMER_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define RTT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RTT_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTT_ASSERT(label, clk, rst, prop, msg)
`define RTT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

### rtl/rtt_pkg.sv
// ----------------------------------------------------------------------------
// Repeating timer table package
// Types, codes and reset constants shared by the timer table modules.
// ----------------------------------------------------------------------------
package rtt_pkg;

   localparam int unsigned TimerSlotsDefault = 16;
   localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;
   localparam logic [15:0] MinPeriodReset = 16'd10;
   localparam logic [31:0] MaxWaitReset = 32'd100000;

   localparam logic [1:0] OpSet = 2'd0;
   localparam logic [1:0] OpKill = 2'd1;
   localparam logic [1:0] OpTick = 2'd2;

   localparam logic [1:0] KindAccept = 2'd0;
   localparam logic [1:0] KindReject = 2'd1;
   localparam logic [1:0] KindExpiry = 2'd2;
   localparam logic [1:0] KindSummary = 2'd3;

   localparam logic CsrMinPeriod = 1'b0;
   localparam logic CsrMaxWait = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] owner;
      logic [31:0] timer_num;
      logic [31:0] period;
      logic [31:0] repeats;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] fired_owner;
      logic [31:0] fired_num;
      logic [31:0] repeats_left;
      logic [31:0] least_wait;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        used;
      logic [15:0] owner;
      logic [31:0] number;
      logic [31:0] period;
      logic [31:0] start;
      logic [31:0] count;
   } slot_type;

   // Command type for the cell at the head of the ring; no module in the project uses it.
   typedef struct packed {
      logic        write;
      logic        kill;
      logic        tick;
      slot_type    data;
   } cell_cmd_type;

endpackage

### rtl/rtt_cell.sv
// ----------------------------------------------------------------------------
// Repeating timer table cell
// One timer slot of the rotating ring; passes its entry to the next cell.
// ----------------------------------------------------------------------------
module rtt_cell
   import rtt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     shift,
   input  slot_type slot_in,
   output slot_type slot_out
);

   slot_type slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.used <= 1'b0;
      end else if (shift) begin
         slot_ff.used <= slot_in.used;
      end
      if (shift) begin
         slot_ff.owner  <= slot_in.owner;
         slot_ff.number <= slot_in.number;
         slot_ff.period <= slot_in.period;
         slot_ff.start  <= slot_in.start;
         slot_ff.count  <= slot_in.count;
      end
   end

   assign slot_out = slot_ff;

endmodule

### rtl/rtt_head.sv
// ----------------------------------------------------------------------------
// Repeating timer table head
// Processes the entry that passes the ring head for set, kill and tick.
// ----------------------------------------------------------------------------
module rtt_head
   import rtt_pkg::*;
(
   input  logic        kill,
   input  logic        tick,
   input  logic        write,
   input  req_type     req,
   input  slot_type    slot_in,
   output slot_type    slot_out,
   output logic        fire,
   output logic [31:0] wait_out,
   output logic        wait_valid
);

   logic [31:0] diff;
   logic        due;

   always_comb begin
      diff = slot_in.start + slot_in.period - req.now;
      due = (diff == 32'd0) || diff[31];
      slot_out = slot_in;
      fire = 1'b0;
      wait_out = diff;
      wait_valid = 1'b0;
      if (write) begin
         slot_out.used   = 1'b1;
         slot_out.owner  = req.owner;
         slot_out.number = req.timer_num;
         slot_out.period = req.period;
         slot_out.start  = req.now;
         slot_out.count  = req.repeats;
      end else if (kill) begin
         if (slot_in.used && slot_in.owner == req.owner &&
             (req.timer_num == AllOnes || slot_in.number == req.timer_num)) begin
            slot_out.used = 1'b0;
         end
      end else if (tick && slot_in.used) begin
         if (slot_in.count == 32'd0) begin
            slot_out.used = 1'b0;
         end else begin
            wait_valid = 1'b1;
            if (due) begin
               fire = 1'b1;
               slot_out.start = req.now;
               wait_out = slot_in.period;
               if (slot_in.count != AllOnes) begin
                  slot_out.count = slot_in.count - 32'd1;
               end
            end
         end
      end
   end

endmodule

### rtl/repeating_timer_table.sv
// ----------------------------------------------------------------------------
// Repeating timer table
// Table of repeating timers keyed by owner and number, held in a cell ring.
// ----------------------------------------------------------------------------
// The slots sit in a ring of cells that rotates by one slot a cycle while a
// scan is not held by a result stall, and during a write pass; each set, kill
// or tick walks the ring through the head logic. A set walks it twice (search,
// then write), a kill or a tick once; an unknown op is rejected without a walk.
// A new item is taken only when the last is done and its result is gone.
// A tick emits one expiry per due timer and then a summary item.
`include "repeating_timer_table_defines.svh"
module repeating_timer_table
   import rtt_pkg::*;
#(
   parameter int unsigned TIMER_SLOTS = TimerSlotsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int unsigned CntW = $clog2(TIMER_SLOTS + 1);
   localparam logic [CntW-1:0] LastPos = CntW'(TIMER_SLOTS - 1);

   typedef enum logic [2:0] {
      IDLE, SCAN, WRITE, SUMMARY, DONE
   } state_type;

   state_type   state_ff;
   req_type     req_ff;
   logic [CntW-1:0] pos_ff;
   logic        found_ff;
   logic        free_ff;
   logic        set_ok_ff;
   logic [31:0] least_ff;
   logic [15:0] min_period_ff;
   logic [31:0] max_wait_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   slot_type    ring [TIMER_SLOTS];
   slot_type    head_out;
   logic        fire;
   logic [31:0] wait_val;
   logic        wait_valid;
   logic        shift;
   logic        head_write;
   logic        rsp_free;
   logic        match;
   logic        write_done_ff;
   logic        write_now;
   logic        rsp_load;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign match = ring[TIMER_SLOTS-1].used &&
                  ring[TIMER_SLOTS-1].owner == req_ff.owner &&
                  ring[TIMER_SLOTS-1].number == req_ff.timer_num;
   assign head_write = (state_ff == WRITE) && set_ok_ff &&
                       (found_ff ? match : !ring[TIMER_SLOTS-1].used);

   assign write_now = head_write && !write_done_ff;

   assign shift = (state_ff == SCAN && rsp_free) || state_ff == WRITE;

   assign rsp_load = (state_ff == IDLE && req_valid && !req_stall &&
                      req_data.op != OpSet && req_data.op != OpKill &&
                      req_data.op != OpTick) ||
                     (state_ff == SCAN && rsp_free && fire) ||
                     (state_ff == SUMMARY && rsp_free);

   rtt_head u_head (
      .kill      (state_ff == SCAN && req_ff.op == OpKill),
      .tick      (state_ff == SCAN && req_ff.op == OpTick),
      .write     (write_now),
      .req       (req_ff),
      .slot_in   (ring[TIMER_SLOTS-1]),
      .slot_out  (head_out),
      .fire      (fire),
      .wait_out  (wait_val),
      .wait_valid(wait_valid)
   );

   for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
      rtt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (shift),
         .slot_in ((g == 0) ? head_out : ring[(g == 0) ? 0 : g-1]),
         .slot_out(ring[g])
      );
   end

   assign req_stall = (state_ff != IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
         min_period_ff <= MinPeriodReset;
         max_wait_ff <= MaxWaitReset;
         pos_ff <= '0;
         found_ff <= 1'b0;
         free_ff <= 1'b0;
         set_ok_ff <= 1'b0;
         write_done_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CsrMinPeriod: min_period_ff <= csr_data[15:0];
               CsrMaxWait: max_wait_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_valid && !req_stall) begin
                  req_ff <= req_data;
                  pos_ff <= '0;
                  found_ff <= 1'b0;
                  free_ff <= 1'b0;
                  write_done_ff <= 1'b0;
                  least_ff <= max_wait_ff;
                  if (req_data.op == OpSet || req_data.op == OpKill ||
                      req_data.op == OpTick) begin
                     state_ff <= SCAN;
                  end else begin
                     rsp_ff <= '{kind: KindReject, last: 1'b1, default: '0};
                  end
               end
            end
            SCAN: begin
               if (rsp_free) begin
                  if (req_ff.op == OpSet) begin
                     if (match) found_ff <= 1'b1;
                     if (!ring[TIMER_SLOTS-1].used) free_ff <= 1'b1;
                  end
                  if (wait_valid && wait_val < least_ff) least_ff <= wait_val;
                  if (fire) begin
                     rsp_ff <= '{kind: KindExpiry,
                                 fired_owner: ring[TIMER_SLOTS-1].owner,
                                 fired_num: ring[TIMER_SLOTS-1].number,
                                 repeats_left: ring[TIMER_SLOTS-1].count,
                                 least_wait: 32'd0, last: 1'b0};
                  end
                  if (pos_ff == LastPos) begin
                     pos_ff <= '0;
                     if (req_ff.op == OpSet) begin
                        set_ok_ff <= (req_ff.period >= {16'd0, min_period_ff}) &&
                                     (found_ff || match || free_ff ||
                                      !ring[TIMER_SLOTS-1].used);
                        state_ff <= WRITE;
                     end else begin
                        state_ff <= SUMMARY;
                     end
                  end else begin
                     pos_ff <= pos_ff + CntW'(1);
                  end
               end
            end
            WRITE: begin
               pos_ff <= pos_ff + CntW'(1);
               if (write_now) write_done_ff <= 1'b1;
               if (pos_ff == LastPos) state_ff <= SUMMARY;
            end
            SUMMARY: begin
               if (rsp_free) begin
                  unique case (req_ff.op)
                     OpTick: rsp_ff <= '{kind: KindSummary, least_wait: least_ff,
                                         last: 1'b1, default: '0};
                     OpSet: rsp_ff <= '{kind: set_ok_ff ? KindAccept : KindReject,
                                        last: 1'b1, default: '0};
                     default: rsp_ff <= '{kind: KindAccept, last: 1'b1,
                                          default: '0};
                  endcase
                  state_ff <= DONE;
               end
            end
            DONE: state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

   `RTT_ASSERT(a_no_accept_busy, clock, reset, (state_ff != IDLE) |-> req_stall, "busy accept")
   `RTT_ASSERT(a_one_write, clock, reset, (write_done_ff && state_ff == WRITE) |-> !write_now, "double write")
   `RTT_ASSERT(a_summary_last, clock, reset, (state_ff == DONE) |-> (rsp_valid_ff && rsp_ff.last), "summary not last")

endmodule

### dv/tb_repeating_timer_table.sv
// ----------------------------------------------------------------------------
// Repeating timer table testbench
// Drives set, kill, tick and unknown-op items with random idling on both channels and
// checks every result against a behavioral timer table kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_repeating_timer_table;
   import rtt_pkg::*;

   localparam int Slots = 16;
   localparam int WatchLimit = 20000;
   localparam logic [1:0] OpUnknown = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = '0;

   repeating_timer_table dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   slot_type    table_model [Slots];
   logic [15:0] min_period_q;
   logic [31:0] max_wait_q;
   rsp_type     expected_rsps [$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;
   bit          idle_enable = 1'b1;
   bit          hold_rsp = 1'b0;
   logic [31:0] now_tick = 0;

   function automatic rsp_type make_rsp(logic [1:0] kind, logic [15:0] own,
                                        logic [31:0] num, logic [31:0] left,
                                        logic [31:0] wait_v, logic fin);
      rsp_type r;
      r.kind = kind;
      r.fired_owner = own;
      r.fired_num = num;
      r.repeats_left = left;
      r.least_wait = wait_v;
      r.last = fin;
      return r;
   endfunction

   task automatic add_expected(rsp_type r);
      expected_rsps = {expected_rsps, r};
   endtask

   task automatic predict_timer_item(req_type q);
      int target;
      logic [31:0] least;
      logic [31:0] diff;
      target = -1;
      least = max_wait_q;
      case (q.op)
         OpSet: begin
            if (q.period >= {16'd0, min_period_q}) begin
               for (int i = 0; i < Slots; i++)
                  if (target < 0 && table_model[i].used && table_model[i].owner == q.owner
                      && table_model[i].number == q.timer_num)
                     target = i;
               for (int i = 0; i < Slots; i++)
                  if (target < 0 && !table_model[i].used)
                     target = i;
            end
            if (target >= 0) begin
               table_model[target] = '{1'b1, q.owner, q.timer_num, q.period, q.now,
                                       q.repeats};
               add_expected(make_rsp(KindAccept, '0, '0, '0, '0, 1'b1));
            end else begin
               add_expected(make_rsp(KindReject, '0, '0, '0, '0, 1'b1));
            end
         end
         OpKill: begin
            for (int i = 0; i < Slots; i++)
               if (table_model[i].used && table_model[i].owner == q.owner &&
                   (q.timer_num == AllOnes || table_model[i].number == q.timer_num))
                  table_model[i].used = 1'b0;
            add_expected(make_rsp(KindAccept, '0, '0, '0, '0, 1'b1));
         end
         OpTick: begin
            for (int i = 0; i < Slots; i++) begin
               if (!table_model[i].used) continue;
               if (table_model[i].count == 0) begin
                  table_model[i].used = 1'b0;
                  continue;
               end
               diff = table_model[i].start + table_model[i].period - q.now;
               if (diff == 0 || diff[31]) begin
                  add_expected(make_rsp(KindExpiry, table_model[i].owner,
                     table_model[i].number, table_model[i].count, '0, 1'b0));
                  table_model[i].start = q.now;
                  diff = table_model[i].period;
                  if (table_model[i].count != AllOnes)
                     table_model[i].count = table_model[i].count - 32'd1;
               end
               if (diff < least) least = diff;
            end
            add_expected(make_rsp(KindSummary, '0, '0, '0, least, 1'b1));
         end
         default: add_expected(make_rsp(KindReject, '0, '0, '0, '0, 1'b1));
      endcase
   endtask

   task automatic send_item(req_type q);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_timer_item(q);
   endtask

   task automatic send_fields(logic [1:0] op, logic [15:0] own, logic [31:0] num,
                              logic [31:0] per, logic [31:0] rep, logic [31:0] now);
      req_type q;
      q = '{op, own, num, per, rep, now};
      send_item(q);
   endtask

   task automatic drain_results();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (2 * Slots + 8) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CsrMinPeriod) min_period_q = value[15:0];
      else max_wait_q = value;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_data !== e) begin
               $display("%0t: result mismatch expected %h actual %h", $time, e, rsp_data);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (!reset && !hold_rsp)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      send_fields(OpSet, 16'h0000, 32'h0, 32'd9, 32'd1, now_tick);
      send_fields(OpSet, 16'hFFFF, AllOnes, 32'd10, AllOnes, now_tick);
      send_fields(OpSet, 16'h0001, 32'h1, 32'd20, 32'd0, now_tick);
      send_fields(OpSet, 16'h0001, 32'h2, AllOnes, 32'd2, now_tick);
      send_fields(OpTick, 16'h0, 32'h0, 32'h0, 32'h0, now_tick + 10);
      send_fields(OpSet, 16'hFFFF, AllOnes, 32'd15, 32'd1, now_tick);
      send_fields(OpTick, 16'hFFFF, AllOnes, AllOnes, AllOnes, now_tick + 15);
      send_fields(OpTick, 16'h0, 32'h0, 32'h0, 32'h0, now_tick + 40);
      send_fields(OpKill, 16'h0001, 32'h5, 0, 0, 0);
      send_fields(OpKill, 16'h0001, AllOnes, 0, 0, 0);
      send_fields(OpUnknown, 16'h1234, 32'h5, 32'd50, 32'd3, 0);
      for (int i = 0; i < Slots + 1; i++)
         send_fields(OpSet, 16'h0007, i, 32'd100, 32'd3, 32'hFFFF_FFF0);
      send_fields(OpTick, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0054);
      send_fields(OpKill, 16'h0007, AllOnes, 0, 0, 0);
      send_fields(OpTick, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0100);
      req_valid <= 1'b0;
      drain_results();
   endtask

   task automatic test_random(int count);
      req_type q;
      for (int n = 0; n < count; n++) begin
         q.owner = 16'($urandom_range(0, 3));
         q.timer_num = $urandom_range(0, 5);
         if ($urandom_range(0, 9) == 0) begin
            q.owner = 16'($urandom);
            q.timer_num = $urandom;
         end
         q.period = $urandom_range(0, 60);
         if ($urandom_range(0, 9) == 0) q.period = $urandom;
         q.repeats = $urandom_range(0, 4);
         if ($urandom_range(0, 5) == 0) q.repeats = $urandom_range(0, 1) ? AllOnes : $urandom;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: q.op = OpSet;
            4: begin
               q.op = OpKill;
               if ($urandom_range(0, 2) == 0) q.timer_num = AllOnes;
            end
            5: q.op = OpUnknown;
            default: q.op = OpTick;
         endcase
         now_tick = now_tick + $urandom_range(0, 30);
         if ($urandom_range(0, 19) == 0) now_tick = $urandom;
         q.now = now_tick;
         send_item(q);
      end
      req_valid <= 1'b0;
      drain_results();
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         begin
            for (int n = 0; n < 12; n++)
               send_fields(OpTick, 16'h0, 32'h0, 32'h0, 32'h0, now_tick + n);
            req_valid <= 1'b0;
         end
      join
      drain_results();
   endtask

   initial begin
      for (int i = 0; i < Slots; i++) table_model[i] = '0;
      min_period_q = MinPeriodReset;
      max_wait_q = MaxWaitReset;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_csr(CsrMinPeriod, 32'd0);
      write_csr(CsrMaxWait, 32'd1);
      test_random(30);
      write_csr(CsrMinPeriod, 32'hFFFF);
      write_csr(CsrMaxWait, AllOnes);
      test_random(20);
      write_csr(CsrMinPeriod, 32'd5);
      write_csr(CsrMaxWait, 32'd40);
      test_backpressure();
      test_random(45);
      idle_enable = 1'b0;
      test_random(32);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### repeating_timer_table.f
+incdir+rtl
rtl/rtt_pkg.sv
rtl/rtt_cell.sv
rtl/rtt_head.sv
rtl/repeating_timer_table.sv
dv/tb_repeating_timer_table.sv
